// ===== rtl/ieel_pkg.sv =====
package ieel_pkg;

    // Command codes carried in the action field
    localparam logic [3:0] ACT_PUSH_BACK  = 4'd0;
    localparam logic [3:0] ACT_PUSH_FRONT = 4'd1;
    localparam logic [3:0] ACT_POP_BACK   = 4'd2;
    localparam logic [3:0] ACT_POP_FRONT  = 4'd3;
    localparam logic [3:0] ACT_INSERT     = 4'd4;
    localparam logic [3:0] ACT_ERASE      = 4'd5;
    localparam logic [3:0] ACT_SET        = 4'd6;
    localparam logic [3:0] ACT_GET        = 4'd7;
    localparam logic [3:0] ACT_CLEAR      = 4'd8;

    // Position width inside the cell row, wide enough for the largest build depth
    localparam int POS_W = 9;

    typedef struct packed {
        logic [3:0]  action;
        logic [4:0]  position;
        logic [31:0] entry_data;
    } in_beat_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] read_data;
        logic [4:0]  entry_count;
        logic        is_full;
        logic        is_empty;
    } out_beat_t;

    // Broadcast from the list control to every cell
    typedef struct packed {
        logic             load;
        logic             shift_up;
        logic             shift_down;
        logic [POS_W-1:0] pos;
    } cell_ctl_t;

endpackage

// ===== rtl/ieel_cell.sv =====
module ieel_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  ieel_pkg::cell_ctl_t   ctl,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] new_data,
    output logic [DATA_WIDTH-1:0] data_q
);

    localparam logic [ieel_pkg::POS_W-1:0] MY_POS = ieel_pkg::POS_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Load at the addressed slot, otherwise take from a neighbor or hold
    always_comb begin
        data_next = data_reg;
        if (ctl.load && (ctl.pos == MY_POS)) begin
            data_next = new_data;
        end else if (ctl.shift_up && (ctl.pos < MY_POS)) begin
            data_next = left_data;
        end else if (ctl.shift_down && (ctl.pos <= MY_POS)) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// ===== rtl/indexed_insert_erase_list.sv =====
// Result: each accepted command beat loads a registered result beat into m_valid and m_data.
// Throughput: one command per cycle while s_ready is high; every entry cell shifts, loads or holds in that cycle.
// Backpressure: s_ready stays high while the result register is empty or being drained.
// Reset (aresetn, synchronous, active low): count cleared, capacity set to DEPTH,
// result register emptied; entry cells are not cleared and hold data only once written.
module indexed_insert_erase_list #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ieel_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ieel_pkg::out_beat_t  m_data,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ieel_pkg::POS_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    // Control registers
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [4:0]          capacity_reg;
    logic                m_valid_reg;
    ieel_pkg::out_beat_t m_data_reg;
    ieel_pkg::out_beat_t m_data_next;

    // Cell row
    ieel_pkg::cell_ctl_t   ctl;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];
    logic [DATA_WIDTH-1:0] new_data;
    logic [DATA_WIDTH-1:0] rd_word;

    logic          fire;
    logic [PW-1:0] cnt_p;
    logic [PW-1:0] cnt_next_p;
    logic [PW-1:0] pos_p;
    logic [PW-1:0] cap_p;
    logic [PW-1:0] eff_cap;
    logic          full_now;
    logic          ok;
    logic          rd_en;

    // Advance the result register whenever it is empty or being taken
    assign s_ready  = !m_valid_reg || m_ready;
    assign fire     = s_valid && s_ready;
    assign new_data = DATA_WIDTH'(s_data.entry_data);

    // Clamp the capacity register into 1..DEPTH
    assign cap_p   = PW'(capacity_reg);
    assign eff_cap = (cap_p == '0) ? PW'(1) : ((cap_p > DEPTH_P) ? DEPTH_P : cap_p);

    assign cnt_p    = PW'(count_reg);
    assign pos_p    = PW'(s_data.position);
    assign full_now = (cnt_p >= eff_cap);

    // Decode the command into a broadcast for the cells and the new count
    always_comb begin
        ctl        = '0;
        ctl.pos    = pos_p;
        count_next = count_reg;
        ok         = 1'b0;
        rd_en      = 1'b0;
        case (s_data.action)
            ieel_pkg::ACT_PUSH_BACK: begin
                if (!full_now) begin
                    ok         = 1'b1;
                    ctl.pos    = cnt_p;
                    ctl.load   = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ieel_pkg::ACT_PUSH_FRONT: begin
                if (!full_now) begin
                    ok           = 1'b1;
                    ctl.pos      = '0;
                    ctl.load     = 1'b1;
                    ctl.shift_up = 1'b1;
                    count_next   = count_reg + CW'(1);
                end
            end
            ieel_pkg::ACT_POP_BACK: begin
                if (count_reg != '0) begin
                    ok         = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            ieel_pkg::ACT_POP_FRONT: begin
                if (count_reg != '0) begin
                    ok             = 1'b1;
                    ctl.pos        = '0;
                    ctl.shift_down = 1'b1;
                    count_next     = count_reg - CW'(1);
                end
            end
            ieel_pkg::ACT_INSERT: begin
                if (!full_now && (pos_p <= cnt_p)) begin
                    ok           = 1'b1;
                    ctl.load     = 1'b1;
                    ctl.shift_up = 1'b1;
                    count_next   = count_reg + CW'(1);
                end
            end
            ieel_pkg::ACT_ERASE: begin
                if (pos_p < cnt_p) begin
                    ok             = 1'b1;
                    ctl.shift_down = 1'b1;
                    count_next     = count_reg - CW'(1);
                end
            end
            ieel_pkg::ACT_SET: begin
                if (pos_p < cnt_p) begin
                    ok       = 1'b1;
                    ctl.load = 1'b1;
                end
            end
            ieel_pkg::ACT_GET: begin
                if (pos_p < cnt_p) begin
                    ok    = 1'b1;
                    rd_en = 1'b1;
                end
            end
            ieel_pkg::ACT_CLEAR: begin
                ok         = 1'b1;
                count_next = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        // Drop every cell action unless the beat is taken this cycle
        if (!fire) begin
            ctl.load       = 1'b0;
            ctl.shift_up   = 1'b0;
            ctl.shift_down = 1'b0;
        end
    end

    // Row of cells; the ends feed back their own word
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;
        assign left_w  = (i == 0) ? cell_q[i] : cell_q[(i == 0) ? 0 : i - 1];
        assign right_w = (i == DEPTH - 1) ? cell_q[i] : cell_q[(i == DEPTH - 1) ? i : i + 1];
        ieel_cell #(
            .IDX        (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .left_data  (left_w),
            .right_data (right_w),
            .new_data   (new_data),
            .data_q     (cell_q[i])
        );
    end

    // Read select: AND-OR across the row, addressed by position
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pos_p == PW'(i)) begin
                rd_word = rd_word | cell_q[i];
            end
        end
    end

    assign cnt_next_p = PW'(count_next);

    always_comb begin
        m_data_next             = '0;
        m_data_next.accepted    = ok;
        m_data_next.read_data   = rd_en ? 32'(rd_word) : 32'd0;
        m_data_next.entry_count = 5'(count_next);
        m_data_next.is_full     = (cnt_next_p >= eff_cap);
        m_data_next.is_empty    = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            capacity_reg <= 5'(DEPTH);
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold while stalled
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/ieel_checker.sv =====
module ieel_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ieel_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input ieel_pkg::out_beat_t m_data
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Every accepted command beat gives a result beat next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result beat after accepted command");

    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_full && m_data.is_empty))
        else $error("list reported both full and empty");

    a_refused_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.accepted |-> m_data.read_data == 32'd0)
        else $error("refused command returned read data");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.action == ieel_pkg::ACT_CLEAR)
        |=> m_data.accepted && (m_data.entry_count == 5'd0) && m_data.is_empty)
        else $error("clear did not empty the list");

endmodule

bind indexed_insert_erase_list ieel_checker u_ieel_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int LIST_DEPTH     = 16;
    localparam int ACTION_MAX     = 15;    // highest code the 4-bit action field can carry
    localparam int POSITION_MAX   = 31;    // highest value the 5-bit position field can carry
    localparam int BURST_MAX      = 19;    // longest idle or stall burst, in cycles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    ieel_pkg::in_beat_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    ieel_pkg::out_beat_t m_data;
    logic                cfg_we    = 1'b0;
    logic [4:0]          cfg_wdata = '0;

    indexed_insert_erase_list #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the list: entries, how many are held, and the capacity register
    logic [31:0] shadow_entries [LIST_DEPTH];
    int unsigned shadow_count    = 0;
    logic [4:0]  shadow_capacity = 5'(LIST_DEPTH);

    ieel_pkg::in_beat_t  pending_cmds [$];      // commands waiting for the driver
    ieel_pkg::out_beat_t expected_results [$];  // one entry per accepted command, oldest first
    int unsigned error_count  = 0;
    int unsigned idle_pct     = 0;      // chance, in percent, of an idle or stall burst
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;

    // Capacity as the list applies it: zero acts as one, anything past the depth as the depth
    function automatic int unsigned capacity_limit();
        if (shadow_capacity == 0) return 1;
        if (shadow_capacity > LIST_DEPTH) return LIST_DEPTH;
        return 32'(shadow_capacity);
    endfunction

    // Open a slot at pos by moving the later entries up one
    function automatic bit list_insert(int unsigned pos, logic [31:0] value);
        if (shadow_count >= capacity_limit() || pos > shadow_count) return 1'b0;
        for (int unsigned i = shadow_count; i > pos; i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
        end
        shadow_entries[pos] = value;
        shadow_count++;
        return 1'b1;
    endfunction

    // Close the slot at pos by moving the later entries down one
    function automatic bit list_erase(int unsigned pos);
        if (pos >= shadow_count) return 1'b0;
        for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
        end
        shadow_count--;
        return 1'b1;
    endfunction

    // Apply one command to the shadow list and return the result beat it must produce
    function automatic ieel_pkg::out_beat_t predict_list_result(ieel_pkg::in_beat_t cmd);
        ieel_pkg::out_beat_t res;
        res = '0;
        case (cmd.action)
            ieel_pkg::ACT_PUSH_BACK:
                res.accepted = list_insert(shadow_count, cmd.entry_data);
            ieel_pkg::ACT_PUSH_FRONT:
                res.accepted = list_insert(0, cmd.entry_data);
            ieel_pkg::ACT_POP_BACK: begin
                if (shadow_count > 0) begin
                    shadow_count--;
                    res.accepted = 1'b1;
                end
            end
            ieel_pkg::ACT_POP_FRONT:
                res.accepted = list_erase(0);
            ieel_pkg::ACT_INSERT:
                res.accepted = list_insert(32'(cmd.position), cmd.entry_data);
            ieel_pkg::ACT_ERASE:
                res.accepted = list_erase(32'(cmd.position));
            ieel_pkg::ACT_SET: begin
                if (cmd.position < shadow_count) begin
                    shadow_entries[cmd.position] = cmd.entry_data;
                    res.accepted = 1'b1;
                end
            end
            ieel_pkg::ACT_GET: begin
                if (cmd.position < shadow_count) begin
                    res.read_data = shadow_entries[cmd.position];
                    res.accepted  = 1'b1;
                end
            end
            ieel_pkg::ACT_CLEAR: begin
                shadow_count = 0;
                res.accepted = 1'b1;
            end
            default: ;  // unknown codes change nothing and are refused
        endcase
        res.entry_count = 5'(shadow_count);
        res.is_full     = (shadow_count >= capacity_limit());
        res.is_empty    = (shadow_count == 0);
        return res;
    endfunction

    function automatic ieel_pkg::in_beat_t make_cmd(logic [3:0] act, logic [4:0] pos,
                                                    logic [31:0] value);
        ieel_pkg::in_beat_t cmd;
        cmd.action     = act;
        cmd.position   = pos;
        cmd.entry_data = value;
        return cmd;
    endfunction

    // Weighted mix: mostly pushes, inserts and reads so the list fills and gets exercised
    // at every depth; the occasional clear empties it again
    function automatic ieel_pkg::in_beat_t random_cmd();
        int unsigned pick;
        logic [3:0]  act;
        logic [4:0]  pos;
        pick = $urandom_range(0, 99);
        if (pick < 20)      act = ieel_pkg::ACT_PUSH_BACK;
        else if (pick < 30) act = ieel_pkg::ACT_PUSH_FRONT;
        else if (pick < 38) act = ieel_pkg::ACT_POP_BACK;
        else if (pick < 45) act = ieel_pkg::ACT_POP_FRONT;
        else if (pick < 60) act = ieel_pkg::ACT_INSERT;
        else if (pick < 70) act = ieel_pkg::ACT_ERASE;
        else if (pick < 80) act = ieel_pkg::ACT_SET;
        else if (pick < 94) act = ieel_pkg::ACT_GET;
        else if (pick < 97) act = ieel_pkg::ACT_CLEAR;
        else act = 4'($urandom_range(int'(ieel_pkg::ACT_CLEAR) + 1, ACTION_MAX));
        // Keep most positions near the held range; let some reach the top of the field
        if ($urandom_range(0, 4) != 0) pos = 5'($urandom_range(0, LIST_DEPTH));
        else                           pos = 5'($urandom_range(0, POSITION_MAX));
        return make_cmd(act, pos, $urandom());
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what);
        $display("%0t ns mismatch: %s", $time, what);
        error_count++;
    endtask

    // Hold until no command is queued or in flight and every result beat has come back
    task automatic wait_for_drain();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // Write the capacity register while the list is idle, and track it in the shadow
    task automatic set_capacity(logic [4:0] value);
        wait_for_drain();
        @(posedge aclk);
        cfg_we          <= 1'b1;
        cfg_wdata       <= value;
        shadow_capacity  = value;
        @(posedge aclk);
        cfg_we          <= 1'b0;
    endtask

    task automatic run_phase(logic [4:0] capacity, int unsigned n_cmds, int unsigned burst_pct);
        set_capacity(capacity);
        idle_pct = burst_pct;
        repeat (n_cmds) pending_cmds.push_back(random_cmd());
    endtask

    task automatic check_result(ieel_pkg::out_beat_t got);
        ieel_pkg::out_beat_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing expected", got));
            return;
        end
        want = expected_results.pop_front();
        if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %b want %b", got.accepted, want.accepted));
        if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %h want %h", got.read_data, want.read_data));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.entry_count, want.entry_count));
        if (got.is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %b want %b", got.is_full, want.is_full));
        if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
    endtask

    // Command driver: predict each accepted beat, then advance to the next queued command
    // or hold off for an idle burst. The payload stays put until its beat is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(predict_list_result(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_cmds.pop_front();
                    if ($urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, BURST_MAX);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat taken, then stall in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, BURST_MAX);
            end
        end
    end

    // Watchdog: any beat on either channel restarts the count
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL indexed_insert_erase_list");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        idle_pct = 15;

        // Directed pass at the reset capacity: work the empty list, build a short list
        // through every write path, read it back, then break it down again
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_POP_BACK,   5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_POP_FRONT,  5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_ERASE,      5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_GET,        5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_SET,        5'd0, 32'hDEAD_BEEF));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_INSERT,     5'd1, 32'h1111_1111));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_PUSH_BACK,  5'd0, 32'h0000_0000));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_PUSH_FRONT, 5'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_INSERT,     5'd2, 32'hA5A5_A5A5));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_INSERT,     5'd1, 32'h5A5A_5A5A));
        for (int i = 0; i < 4; i++) begin
            pending_cmds.push_back(make_cmd(ieel_pkg::ACT_GET, 5'(i), 32'h0));
        end
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_GET,        5'd4, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_GET,        5'(POSITION_MAX), 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_SET,        5'd3, 32'h1234_5678));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_SET,        5'(LIST_DEPTH), 32'h8765_4321));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_INSERT,     5'(POSITION_MAX),
                                        32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_ERASE,      5'd1, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_POP_FRONT,  5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_POP_BACK,   5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(4'(int'(ieel_pkg::ACT_CLEAR) + 1), 5'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(4'(ACTION_MAX), 5'(POSITION_MAX), 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_GET,        5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(ieel_pkg::ACT_CLEAR,      5'd0, 32'h0));

        // Random phases, each started once all queued commands have drained, with a fresh capacity
        run_phase(5'd1, 40, 10);                          // one slot: full after one push
        run_phase(5'(LIST_DEPTH), 180, 20);               // whole depth, heavy idling
        run_phase(5'd4, 50, 30);                          // lowered below the held count
        run_phase(5'd0, 40, 10);                          // zero behaves as one
        run_phase(5'(POSITION_MAX), 60, 25);              // top of the register clamps
        run_phase(5'($urandom_range(2, LIST_DEPTH - 1)), 50, 15);
        run_phase(5'($urandom_range(LIST_DEPTH + 1, POSITION_MAX - 1)), 30, 5);
        run_phase(5'(LIST_DEPTH), 60, 0);                 // closing stretch at full rate

        wait_for_drain();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS indexed_insert_erase_list");
        end else begin
            $display("FAIL indexed_insert_erase_list");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ieel_pkg.sv
rtl/ieel_cell.sv
rtl/indexed_insert_erase_list.sv
rtl/ieel_checker.sv
verif/tb_top.sv
